// ===== hdl/fsgs_pkg.sv =====
// shared types and constants for the falling sand grid step unit
// no dependencies; imported by every module of the block but the checker
package fsgs_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;
   localparam int COL_BITS    = $clog2(GRID_WIDTH);
   localparam int ROW_BITS    = $clog2(GRID_HEIGHT);
   localparam int LINE_BITS   = 2 * GRID_WIDTH;
   localparam int LFSR_BITS   = 16;
   localparam int COLOR_BITS  = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;

   typedef enum logic [1:0] {
      MAT_EMPTY = 2'd0,
      MAT_SAND  = 2'd1,
      MAT_WATER = 2'd2,
      MAT_STONE = 2'd3
   } mat_type;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_STEP  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_EMPTY_COLOR = 3'd0,
      CSR_SAND_COLOR  = 3'd1,
      CSR_WATER_COLOR = 3'd2,
      CSR_STONE_COLOR = 3'd3,
      CSR_RANDOM_SEED = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_LOAD_BELOW,
      ST_LOAD_CUR,
      ST_SCAN,
      ST_WB_BELOW,
      ST_WB_TOP,
      ST_DONE
   } state_type;

   // controls from the sequencer to the row engine
   typedef struct packed {
      logic load_cur;
      logic load_below;
      logic cur_to_below;
      logic shift;
      logic at_left;
      logic at_right;
      logic dir_left;
   } eng_ctl_type;

endpackage

// ===== hdl/fsgs_row_ram.sv =====
// grid row memory: one row of cells per word, one write and one read port
// depends on fsgs_pkg
module fsgs_row_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [fsgs_pkg::ROW_BITS-1:0]  wr_addr,
   input  logic [fsgs_pkg::LINE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [fsgs_pkg::ROW_BITS-1:0]  rd_addr,
   output logic [fsgs_pkg::LINE_BITS-1:0] rd_data
);
   import fsgs_pkg::*;

   logic [LINE_BITS-1:0] mem [GRID_HEIGHT];
   logic [LINE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fsgs_row_engine.sv =====
// row engine: two rotating row buffers (current row and the row below)
// one cell updated per shift; depends on fsgs_pkg
module fsgs_row_engine (
   input  logic                          clock,
   input  fsgs_pkg::eng_ctl_type          ctl,
   input  logic [fsgs_pkg::LINE_BITS-1:0] load_row,
   output logic                          lfsr_adv,
   output logic [fsgs_pkg::LINE_BITS-1:0] cur_row,
   output logic [fsgs_pkg::LINE_BITS-1:0] below_row
);
   import fsgs_pkg::*;

   // tap k holds cell (x + k - 1) mod width: tap 1 is the cell in work
   mat_type cur_ff   [GRID_WIDTH];
   mat_type below_ff [GRID_WIDTH];
   mat_type cur_mod  [GRID_WIDTH];
   mat_type below_mod[GRID_WIDTH];
   logic    adv;

   always_comb begin
      cur_mod   = cur_ff;
      below_mod = below_ff;
      adv       = 1'b0;
      case (cur_ff[1])
         MAT_SAND: begin
            if (below_ff[1] == MAT_EMPTY) begin
               cur_mod[1]   = MAT_EMPTY;
               below_mod[1] = MAT_SAND;
            end else if (!ctl.at_left && below_ff[0] == MAT_EMPTY) begin
               cur_mod[1]   = MAT_EMPTY;
               below_mod[0] = MAT_SAND;
            end else if (!ctl.at_right && below_ff[2] == MAT_EMPTY) begin
               cur_mod[1]   = MAT_EMPTY;
               below_mod[2] = MAT_SAND;
            end
         end
         MAT_WATER: begin
            if (below_ff[1] == MAT_EMPTY) begin
               cur_mod[1]   = MAT_EMPTY;
               below_mod[1] = MAT_WATER;
            end else begin
               adv = 1'b1;
               if (ctl.dir_left && !ctl.at_left && cur_ff[0] == MAT_EMPTY) begin
                  cur_mod[1] = MAT_EMPTY;
                  cur_mod[0] = MAT_WATER;
               end else if (!ctl.dir_left && !ctl.at_right && cur_ff[2] == MAT_EMPTY) begin
                  cur_mod[1] = MAT_EMPTY;
                  cur_mod[2] = MAT_WATER;
               end
            end
         end
         default: begin
            adv = 1'b0;
         end
      endcase
   end

   assign lfsr_adv = ctl.shift & adv;

   always_ff @(posedge clock) begin
      for (int k = 0; k < GRID_WIDTH; k++) begin
         if (ctl.load_cur) begin
            cur_ff[k] <= mat_type'(load_row[2*((k+GRID_WIDTH-1)%GRID_WIDTH) +: 2]);
         end else if (ctl.shift) begin
            cur_ff[k] <= cur_mod[(k+1)%GRID_WIDTH];
         end
         if (ctl.load_below) begin
            below_ff[k] <= mat_type'(load_row[2*((k+GRID_WIDTH-1)%GRID_WIDTH) +: 2]);
         end else if (ctl.cur_to_below) begin
            below_ff[k] <= cur_ff[k];
         end else if (ctl.shift) begin
            below_ff[k] <= below_mod[(k+1)%GRID_WIDTH];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
         cur_row[2*c +: 2]   = cur_ff[(c+1)%GRID_WIDTH];
         below_row[2*c +: 2] = below_ff[(c+1)%GRID_WIDTH];
      end
   end

endmodule

// ===== hdl/falling_sand_grid_step_unit.sv =====
// falling sand grid step unit: single-cell read and write, and a whole-grid step
// (a step scans 63 rows, each: one row load, one cell per cycle, one row write-back)
// one item at a time; the next item is taken while a result waits in the output register
// reset: synchronous, active high; row valid bits clear so the grid reads empty at once
// (no clearing pass); colors reset to 0, seed and lfsr to 1
module falling_sand_grid_step_unit (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // col_x[5:0], row_y[11:6], new_material[13:12], zero pad
   input  logic [1:0]  req_tuser,  // func[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // cell_material[1:0], pixel_color[33:2], zero pad
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import fsgs_pkg::*;

   state_type state_ff, state_in;

   // latched request
   func_type             func_ff;
   logic [5:0]           col_ff;
   logic [5:0]           row_ff;
   mat_type              mat_ff;

   // scan position
   logic [COL_BITS-1:0]  x_ff;
   logic [ROW_BITS-1:0]  ry_ff;

   // pending result and output register
   mat_type              pend_mat_ff;
   logic [COLOR_BITS-1:0] pend_color_ff;
   logic                 rsp_valid_ff;
   mat_type              rsp_mat_ff;
   logic [COLOR_BITS-1:0] rsp_color_ff;

   logic [COLOR_BITS-1:0] palette_ff [4];
   logic [LFSR_BITS-1:0] lfsr_ff;
   logic [GRID_HEIGHT-1:0] row_vld_ff;
   logic                 rd_vld_ff;

   // memory and engine controls
   logic                 rd_en, wr_en;
   logic [ROW_BITS-1:0]  rd_addr, wr_addr;
   logic [LINE_BITS-1:0] wr_data, ram_q, row_q;
   eng_ctl_type          eng_ctl;
   logic                 lfsr_adv;
   logic [LINE_BITS-1:0] cur_row, below_row;

   // incoming fields
   logic [5:0]           in_col, in_row;
   func_type             in_func;
   logic                 in_inside, req_acc, out_free;
   logic                 ff_inside;
   mat_type              q_mat;

   assign in_col   = req_tdata[5:0];
   assign in_row   = req_tdata[11:6];
   assign in_func  = func_type'(req_tuser);
   assign in_inside = (32'(in_col) < GRID_WIDTH) && (32'(in_row) < GRID_HEIGHT);
   assign ff_inside = (32'(col_ff) < GRID_WIDTH) && (32'(row_ff) < GRID_HEIGHT);
   assign req_acc  = req_tvalid & req_tready;
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign csr_ready = 1'b1;

   // rows never written read as empty
   assign row_q = rd_vld_ff ? ram_q : '0;
   assign q_mat = mat_type'(row_q[2*COL_BITS'(col_ff) +: 2]);

   fsgs_row_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   fsgs_row_engine u_engine (
      .clock     (clock),
      .ctl       (eng_ctl),
      .load_row  (row_q),
      .lfsr_adv  (lfsr_adv),
      .cur_row   (cur_row),
      .below_row (below_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (in_func == FUNC_STEP) begin
                  state_in = ST_LOAD_BELOW;
               end else if ((in_func == FUNC_READ || in_func == FUNC_WRITE) && in_inside) begin
                  state_in = ST_ACCESS;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ACCESS:     state_in = ST_DONE;
         ST_LOAD_BELOW: state_in = ST_LOAD_CUR;
         ST_LOAD_CUR:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (32'(x_ff) == GRID_WIDTH - 1) begin
               state_in = ST_WB_BELOW;
            end
         end
         ST_WB_BELOW: begin
            state_in = (ry_ff == '0) ? ST_WB_TOP : ST_LOAD_CUR;
         end
         ST_WB_TOP: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = ry_ff;
      wr_en      = 1'b0;
      wr_addr    = ry_ff;
      wr_data    = below_row;
      eng_ctl    = '0;
      eng_ctl.at_left  = (x_ff == '0);
      eng_ctl.at_right = (32'(x_ff) == GRID_WIDTH - 1);
      eng_ctl.dir_left = lfsr_ff[0];
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_en      = req_tvalid;
            // a step starts from the bottom row
            rd_addr    = (in_func == FUNC_STEP) ? ROW_BITS'(GRID_HEIGHT - 1)
                                                : ROW_BITS'(in_row);
         end
         ST_ACCESS: begin
            wr_en   = (func_ff == FUNC_WRITE);
            wr_addr = ROW_BITS'(row_ff);
            wr_data = row_q;
            wr_data[2*COL_BITS'(col_ff) +: 2] = mat_ff;
         end
         ST_LOAD_BELOW: begin
            eng_ctl.load_below = 1'b1;
            rd_en   = 1'b1;
            rd_addr = ry_ff;
         end
         ST_LOAD_CUR: begin
            eng_ctl.load_cur = 1'b1;
         end
         ST_SCAN: begin
            eng_ctl.shift = 1'b1;
         end
         ST_WB_BELOW: begin
            wr_en   = 1'b1;
            wr_addr = ry_ff + 1'b1;
            wr_data = below_row;
            if (ry_ff != '0) begin
               eng_ctl.cur_to_below = 1'b1;
               rd_en   = 1'b1;
               rd_addr = ry_ff - 1'b1;
            end
         end
         ST_WB_TOP: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = cur_row;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         lfsr_ff      <= LFSR_BITS'(1);
         for (int i = 0; i < 4; i++) begin
            palette_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         // register writes; the seed also restarts the lfsr
         if (csr_valid) begin
            case (csr_idx_type'(csr_index))
               CSR_EMPTY_COLOR: palette_ff[0] <= csr_data;
               CSR_SAND_COLOR:  palette_ff[1] <= csr_data;
               CSR_WATER_COLOR: palette_ff[2] <= csr_data;
               CSR_STONE_COLOR: palette_ff[3] <= csr_data;
               CSR_RANDOM_SEED: begin
                  lfsr_ff <= (csr_data[15:0] == '0) ? LFSR_BITS'(1) : csr_data[15:0];
               end
               default: begin
                  lfsr_ff <= lfsr_ff;
               end
            endcase
         end else if (lfsr_adv) begin
            lfsr_ff <= (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         func_ff       <= in_func;
         col_ff        <= in_col;
         row_ff        <= in_row;
         mat_ff        <= mat_type'(req_tdata[13:12]);
         ry_ff         <= ROW_BITS'(GRID_HEIGHT - 2);
         pend_mat_ff   <= MAT_EMPTY;
         pend_color_ff <= '0;
      end
      if (state_ff == ST_ACCESS && func_ff == FUNC_READ && ff_inside) begin
         pend_mat_ff   <= q_mat;
         pend_color_ff <= palette_ff[q_mat];
      end
      if (state_ff == ST_LOAD_CUR) begin
         x_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         x_ff <= x_ff + 1'b1;
      end
      if (state_ff == ST_WB_BELOW && ry_ff != '0) begin
         ry_ff <= ry_ff - 1'b1;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_mat_ff   <= pend_mat_ff;
         rsp_color_ff <= pend_color_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_color_ff, rsp_mat_ff};

endmodule

// ===== hdl/fsgs_checker.sv =====
// port-level checks for the falling sand grid step unit, with its bind
// depends on falling_sand_grid_step_unit ports only
module fsgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'b0)
      else $error("response pad bits not zero");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

   // one word in work at a time: a taken request drops ready on the next cycle
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on back-to-back cycles");

endmodule

bind falling_sand_grid_step_unit fsgs_checker u_fsgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
